FILE: hdl/pph_pkg.sv
// shared types, constants and helpers for the path prune and heading block
`timescale 1ns / 1ps
package pph_pkg;

    localparam int WORD_W     = 192;
    localparam int DIFF_W     = 33;
    localparam int QDEPTH     = 4;
    localparam int QAW        = 2;
    localparam int QLW        = 3;
    localparam int CNT_W      = 6;
    localparam int SQ_STEPS   = 32;
    localparam int DIV_STEPS  = 60;
    localparam int FRAC_SHIFT = 27;
    localparam int THR_W      = 31;

    localparam logic [15:0] Q_ONE = 16'd16384;
    localparam logic [WORD_W-1:0] ORIGIN_WORD = {32'd0, Q_ONE, 144'd0};

    localparam logic CFG_PRUNE  = 1'b0;
    localparam logic CFG_THRESH = 1'b1;

    // word layout: x, y, z, rot x, rot y, rot z, rot w, stamp from the lowest bit
    typedef struct packed {
        logic [WORD_W-1:0]        data;
        logic                     eop;
        logic                     head;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } cmd_t;

    typedef enum logic [2:0] {F_IDLE, F_DIFF, F_MUL, F_DEC, F_P2} front_state_t;
    typedef enum logic [2:0] {Y_IDLE, Y_MUL, Y_ROOT, Y_DIVW, Y_SQW, Y_DIVZ, Y_SQZ,
                              Y_DONE} yaw_state_t;
    typedef enum logic [1:0] {B_IDLE, B_WAIT, B_EMIT} back_state_t;

    function automatic cmd_t mk_cmd(input logic [WORD_W-1:0] data, input logic eop,
                                    input logic head, input logic signed [DIFF_W-1:0] dx,
                                    input logic signed [DIFF_W-1:0] dy);
        cmd_t c;
        c.data = data;
        c.eop  = eop;
        c.head = head;
        c.dx   = dx;
        c.dy   = dy;
        return c;
    endfunction

endpackage

FILE: hdl/pph_front.sv
// front end: takes pose words, holds the last kept pose, decides keep or drop
`timescale 1ns / 1ps
module pph_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [pph_pkg::WORD_W-1:0] s_tdata,
    input  logic                      s_tuser,
    input  logic                      s_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [30:0]               cfg_data,
    input  logic [pph_pkg::QLW-1:0]   q_level,
    output logic                      push,
    output pph_pkg::cmd_t             push_cmd
);
    import pph_pkg::*;

    front_state_t state_reg, state_next;
    logic [WORD_W-1:0] in_reg, held_reg;
    logic in_first_reg, in_last_reg, held_valid_reg;
    logic prune_reg;
    logic [THR_W-1:0] thr_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [DIFF_W-1:0] ax_reg, ay_reg;
    logic big_reg;
    logic [61:0] asq_reg, bsq_reg, thr_sq_reg;
    cmd_t pend_reg;
    logic pend_v_reg;

    logic signed [DIFF_W-1:0] dx_c, dy_c;
    logic keep;
    logic c1v, c2v;
    cmd_t c1, c2;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == F_IDLE) && (q_level <= QLW'(QDEPTH - 2));

    assign dx_c = $signed({in_reg[31], in_reg[31:0]}) - $signed({held_reg[31], held_reg[31:0]});
    assign dy_c = $signed({in_reg[63], in_reg[63:32]}) - $signed({held_reg[63], held_reg[63:32]});

    assign keep = !prune_reg || big_reg ||
                  ({1'b0, asq_reg} + {1'b0, bsq_reg} > {1'b0, thr_sq_reg});

    always_comb begin
        c1v = 1'b0;
        c2v = 1'b0;
        c1  = mk_cmd(held_reg, 1'b1, 1'b0, dx_reg, dy_reg);
        c2  = mk_cmd(ORIGIN_WORD, 1'b1, 1'b0, dx_reg, dy_reg);
        if (in_first_reg) begin
            c1v = held_valid_reg;
            c2v = in_last_reg;
        end else if (held_valid_reg) begin
            if (keep) begin
                c1v = 1'b1;
                c1  = mk_cmd(held_reg, 1'b0, 1'b1, dx_reg, dy_reg);
                c2v = in_last_reg;
                c2  = mk_cmd(in_reg, 1'b1, 1'b0, dx_reg, dy_reg);
            end else if (in_last_reg) begin
                c1v = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        push       = 1'b0;
        push_cmd   = c1;
        unique case (state_reg)
            F_IDLE: if (s_tvalid && s_tready) state_next = F_DIFF;
            F_DIFF: state_next = F_MUL;
            F_MUL:  state_next = F_DEC;
            F_DEC: begin
                push       = c1v;
                state_next = F_P2;
            end
            F_P2: begin
                push       = pend_v_reg;
                push_cmd   = pend_reg;
                state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_reg       <= '0;
            prune_reg      <= 1'b1;
            thr_reg        <= THR_W'(6554);
            pend_v_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_PRUNE:  prune_reg <= cfg_data[0];
                    CFG_THRESH: thr_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == F_DEC) begin
                pend_reg   <= c2;
                pend_v_reg <= c2v;
                if (in_first_reg) begin
                    held_reg       <= ORIGIN_WORD;
                    held_valid_reg <= !in_last_reg;
                end else if (held_valid_reg) begin
                    if (keep) begin
                        held_reg       <= in_reg;
                        held_valid_reg <= !in_last_reg;
                    end else if (in_last_reg) begin
                        held_valid_reg <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg       <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
        if (state_reg == F_DIFF) begin
            dx_reg  <= dx_c;
            dy_reg  <= dy_c;
            ax_reg  <= dx_c[DIFF_W-1] ? DIFF_W'(-dx_c) : DIFF_W'(dx_c);
            ay_reg  <= dy_c[DIFF_W-1] ? DIFF_W'(-dy_c) : DIFF_W'(dy_c);
        end
        if (state_reg == F_MUL) begin
            big_reg    <= (ax_reg[32:31] != 2'b00) || (ay_reg[32:31] != 2'b00);
            asq_reg    <= ax_reg[30:0] * ax_reg[30:0];
            bsq_reg    <= ay_reg[30:0] * ay_reg[30:0];
            thr_sq_reg <= thr_reg * thr_reg;
        end
    end

endmodule

FILE: hdl/pph_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps
module pph_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  pph_pkg::cmd_t           push_cmd,
    input  logic                    pop,
    output pph_pkg::cmd_t           head_cmd,
    output logic                    empty,
    output logic [pph_pkg::QLW-1:0] level
);
    import pph_pkg::*;

    cmd_t mem [QDEPTH];
    logic [QAW-1:0] wr_reg, rd_reg;
    logic [QLW-1:0] cnt_reg;

    assign head_cmd = mem[rd_reg];
    assign empty    = (cnt_reg == '0);
    assign level    = cnt_reg;

    always_ff @(posedge aclk) begin
        if (push) mem[wr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + QLW'(push) - QLW'(pop);
        end
    end

endmodule

FILE: hdl/pph_yaw.sv
// iterative yaw quaternion unit: square root, then divide and square root twice
`timescale 1ns / 1ps
module pph_yaw (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [pph_pkg::DIFF_W-1:0]   dx,
    input  logic signed [pph_pkg::DIFF_W-1:0]   dy,
    output logic                                done,
    output logic [15:0]                         qz,
    output logic [15:0]                         qw
);
    import pph_pkg::*;

    yaw_state_t state_reg, state_next;
    logic [30:0] a_reg, b_reg;
    logic negx_reg, negy_reg;
    logic [63:0] n_reg;
    logic [32:0] rem_reg;
    logic [31:0] root_reg, r_reg;
    logic [59:0] dvn_reg;
    logic [32:0] dvr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0] qz_reg, qw_reg;

    logic [DIFF_W-1:0] ax, ay, orv;
    logic [30:0] as, bs;
    logic [61:0] asq_c, bsq_c;
    logic [34:0] rem_sh, trial, rem_next;
    logic sq_ge;
    logic [31:0] root_next;
    logic [32:0] dr_sh, dvr_next;
    logic dv_ge;
    logic [59:0] dvn_next;
    logic [32:0] up_c, dn_c;
    logic sq_last, dv_last;

    assign ax  = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    assign ay  = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    assign orv = ax | ay;
    always_comb begin
        if (orv[32]) begin
            as = ax[32:2];
            bs = ay[32:2];
        end else if (orv[31]) begin
            as = ax[31:1];
            bs = ay[31:1];
        end else begin
            as = ax[30:0];
            bs = ay[30:0];
        end
    end

    assign asq_c = a_reg * a_reg;
    assign bsq_c = b_reg * b_reg;

    assign rem_sh    = {rem_reg, n_reg[63:62]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign sq_ge     = rem_sh >= trial;
    assign rem_next  = sq_ge ? rem_sh - trial : rem_sh;
    assign root_next = {root_reg[30:0], sq_ge};

    assign dr_sh    = {dvr_reg[31:0], dvn_reg[59]};
    assign dv_ge    = dr_sh >= {1'b0, r_reg};
    assign dvr_next = dv_ge ? dr_sh - {1'b0, r_reg} : dr_sh;
    assign dvn_next = {dvn_reg[58:0], dv_ge};

    assign up_c = negx_reg ? {1'b0, root_next} - {2'b0, a_reg} : {1'b0, root_next} + {2'b0, a_reg};
    assign dn_c = negx_reg ? {1'b0, r_reg} + {2'b0, a_reg} : {1'b0, r_reg} - {2'b0, a_reg};

    assign sq_last = (cnt_reg == CNT_W'(SQ_STEPS - 1));
    assign dv_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    assign done = (state_reg == Y_DONE);
    assign qz   = qz_reg;
    assign qw   = qw_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            Y_IDLE: if (start) state_next = Y_MUL;
            Y_MUL:  state_next = Y_ROOT;
            Y_ROOT: if (sq_last) state_next = (root_next == '0) ? Y_DONE : Y_DIVW;
            Y_DIVW: if (dv_last) state_next = Y_SQW;
            Y_SQW:  if (sq_last) state_next = Y_DIVZ;
            Y_DIVZ: if (dv_last) state_next = Y_SQZ;
            Y_SQZ:  if (sq_last) state_next = Y_DONE;
            Y_DONE: state_next = Y_IDLE;
            default: state_next = Y_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= Y_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            Y_IDLE: begin
                a_reg    <= as;
                b_reg    <= bs;
                negx_reg <= dx[DIFF_W-1];
                negy_reg <= dy[DIFF_W-1];
            end
            Y_MUL: begin
                n_reg    <= {2'b0, asq_c} + {2'b0, bsq_c};
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            Y_ROOT, Y_SQW, Y_SQZ: begin
                n_reg    <= {n_reg[61:0], 2'b00};
                rem_reg  <= rem_next[32:0];
                root_reg <= root_next;
                cnt_reg  <= cnt_reg + 1'b1;
                if (sq_last) begin
                    cnt_reg <= '0;
                    dvr_reg <= '0;
                    if (state_reg == Y_ROOT) begin
                        r_reg   <= root_next;
                        dvn_reg <= {up_c, FRAC_SHIFT'(0)};
                        if (root_next == '0) begin
                            qz_reg <= '0;
                            qw_reg <= Q_ONE;
                        end
                    end else if (state_reg == Y_SQW) begin
                        qw_reg  <= root_next[15:0];
                        dvn_reg <= {dn_c, FRAC_SHIFT'(0)};
                    end else begin
                        qz_reg <= negy_reg ? 16'(-root_next[15:0]) : root_next[15:0];
                    end
                end
            end
            Y_DIVW, Y_DIVZ: begin
                dvn_reg <= dvn_next;
                dvr_reg <= dvr_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (dv_last) begin
                    n_reg    <= {35'd0, dvn_next[28:0]};
                    rem_reg  <= '0;
                    root_reg <= '0;
                    cnt_reg  <= '0;
                end
            end
            Y_DONE: ;
            default: ;
        endcase
    end

endmodule

FILE: hdl/pph_back.sv
// back end: drains commands, runs the heading unit, drives the output register
`timescale 1ns / 1ps
module pph_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_empty,
    input  pph_pkg::cmd_t              head_cmd,
    output logic                       pop,
    output logic                       yaw_start,
    input  logic                       yaw_done,
    input  logic [15:0]                yaw_qz,
    input  logic [15:0]                yaw_qw,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [pph_pkg::WORD_W-1:0] m_tdata,
    output logic                       m_tlast
);
    import pph_pkg::*;

    back_state_t state_reg, state_next;
    cmd_t cur_reg;
    logic out_v_reg, out_eop_reg;
    logic [WORD_W-1:0] out_data_reg;
    logic slot_free, load_plain, load_head;

    assign slot_free = !out_v_reg || m_tready;
    assign m_tvalid  = out_v_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_eop_reg;

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        yaw_start  = 1'b0;
        load_plain = 1'b0;
        load_head  = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    if (head_cmd.head) begin
                        pop        = 1'b1;
                        yaw_start  = 1'b1;
                        state_next = B_WAIT;
                    end else if (slot_free) begin
                        pop        = 1'b1;
                        load_plain = 1'b1;
                    end
                end
            end
            B_WAIT: if (yaw_done) state_next = B_EMIT;
            B_EMIT: begin
                if (slot_free) begin
                    load_head  = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_plain || load_head) out_v_reg <= 1'b1;
            else if (m_tready)          out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (yaw_start) cur_reg <= head_cmd;
        if (load_plain) begin
            out_data_reg <= head_cmd.data;
            out_eop_reg  <= head_cmd.eop;
        end else if (load_head) begin
            out_data_reg <= {cur_reg.data[191:160], yaw_qw, yaw_qz, 32'd0,
                             cur_reg.data[95:0]};
            out_eop_reg  <= cur_reg.eop;
        end
    end

endmodule

FILE: hdl/path_prune_heading.sv
// top level of the path prune and heading block
// flow: a plain word passes the front states, the queue and the output register;
// a heading word also waits in the back end for the iterative root and divide unit
// input: a new word is taken only once the front has finished the last one and the
// queue has room; heading words drain one at a time through the single yaw unit
// reset: synchronous active low; clears control, nothing held, pruning on, 0.1 m
`timescale 1ns / 1ps
module path_prune_heading (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, rot_w, stamp
    input  logic         s_tuser,   // first_pose
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // out_x, out_y, out_z, out_qx, out_qy, out_qz, out_qw, out_stamp
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [30:0]  cfg_data
);
    import pph_pkg::*;

    logic push, pop, q_empty, yaw_start, yaw_done;
    cmd_t push_cmd, head_cmd;
    logic [QLW-1:0] q_level;
    logic [15:0] yaw_qz, yaw_qw;

    pph_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .q_level, .push, .push_cmd
    );

    pph_queue u_queue (
        .aclk, .aresetn, .push, .push_cmd, .pop, .head_cmd,
        .empty(q_empty), .level(q_level)
    );

    pph_yaw u_yaw (
        .aclk, .aresetn, .start(yaw_start), .dx(head_cmd.dx), .dy(head_cmd.dy),
        .done(yaw_done), .qz(yaw_qz), .qw(yaw_qw)
    );

    pph_back u_back (
        .aclk, .aresetn, .q_empty, .head_cmd, .pop, .yaw_start, .yaw_done,
        .yaw_qz, .yaw_qw, .m_tvalid, .m_tready, .m_tdata, .m_tlast
    );

endmodule

FILE: hdl/pph_checker.sv
// port checks for the path prune and heading block
`timescale 1ns / 1ps
module pph_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic         cfg_valid,
    input logic         cfg_ready
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("output word dropped");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("output word changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("output valid after reset");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready) else $error("config write stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("input taken while busy");

endmodule

bind path_prune_heading pph_checker u_pph_checker (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready
);

FILE: tb/sv/pph_pose_checker.sv
// pose checker: watches the channels, predicts kept and headed poses, compares results
`timescale 1ns / 1ps
module pph_pose_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [191:0] s_tdata,
    input  logic         s_tuser,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [191:0] m_tdata,
    input  logic         m_tlast,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [30:0]  cfg_data,
    output int           errors,
    output int           pending,
    output int           headed_seen,
    output int           ends_seen
);
    import pph_pkg::*;

    typedef struct {
        logic [191:0] word;
        logic         eop;
    } pose_out_t;

    pose_out_t due_poses[$];

    logic        prune_on;
    logic [30:0] min_gap;
    logic [31:0] kept_pos[3];
    logic [15:0] kept_rot[4];
    logic [31:0] kept_stamp;
    logic        kept_valid;

    assign pending = due_poses.size();

    function automatic longint unsigned root64(input longint unsigned n);
        longint unsigned res, bit_v;
        res   = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n   -= res + bit_v;
                res  = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    // returns {qw, qz, qy, qx}
    function automatic logic [63:0] heading_quat(input longint dx, input longint dy);
        longint unsigned a, b, r, up, dn, qw, qz;
        logic [15:0] z16;
        a = (dx < 0) ? -dx : dx;
        b = (dy < 0) ? -dy : dy;
        while (a >= 64'h8000_0000 || b >= 64'h8000_0000) begin
            a >>= 1;
            b >>= 1;
        end
        r = root64(a * a + b * b);
        if (r == 0) return {Q_ONE, 16'd0, 16'd0, 16'd0};
        if (dx >= 0) begin
            up = r + a;
            dn = r - a;
        end else begin
            up = r - a;
            dn = r + a;
        end
        qw  = root64((up << FRAC_SHIFT) / r);
        qz  = root64((dn << FRAC_SHIFT) / r);
        z16 = (dy < 0) ? 16'(-qz) : 16'(qz);
        return {16'(qw), z16, 16'd0, 16'd0};
    endfunction

    function automatic logic [191:0] pose_word(input logic [31:0] p[3],
                                               input logic [63:0] q, input logic [31:0] st);
        return {st, q, p[2], p[1], p[0]};
    endfunction

    function automatic logic [63:0] rot_word(input logic [15:0] q[4]);
        return {q[3], q[2], q[1], q[0]};
    endfunction

    task automatic push_pose(input logic [191:0] w, input logic eop);
        pose_out_t o;
        o.word = w;
        o.eop  = eop;
        due_poses.insert(due_poses.size(), o);
    endtask

    task automatic prune_step(input logic [191:0] d, input logic first, input logic last);
        logic [31:0] np[3];
        logic [15:0] nq[4];
        longint dx, dy;
        longint unsigned a, b;
        logic keep;
        for (int i = 0; i < 3; i++) np[i] = d[32*i +: 32];
        for (int i = 0; i < 4; i++) nq[i] = d[96 + 16*i +: 16];
        if (first) begin
            if (kept_valid)
                push_pose(pose_word(kept_pos, rot_word(kept_rot), kept_stamp), 1'b1);
            for (int i = 0; i < 3; i++) kept_pos[i] = '0;
            kept_rot   = '{16'd0, 16'd0, 16'd0, Q_ONE};
            kept_stamp = '0;
            kept_valid = 1'b1;
            if (last) begin
                push_pose(pose_word(kept_pos, rot_word(kept_rot), kept_stamp), 1'b1);
                kept_valid = 1'b0;
            end
            return;
        end
        if (!kept_valid) return;
        dx = longint'(signed'(np[0])) - longint'(signed'(kept_pos[0]));
        dy = longint'(signed'(np[1])) - longint'(signed'(kept_pos[1]));
        a  = (dx < 0) ? -dx : dx;
        b  = (dy < 0) ? -dy : dy;
        if (!prune_on) keep = 1'b1;
        else if (a >= 64'h8000_0000 || b >= 64'h8000_0000) keep = 1'b1;
        else keep = (a * a + b * b) > (longint'(min_gap) * longint'(min_gap));
        if (keep) begin
            push_pose(pose_word(kept_pos, heading_quat(dx, dy), kept_stamp), 1'b0);
            kept_pos   = np;
            kept_rot   = nq;
            kept_stamp = d[191:160];
            if (last) begin
                push_pose(pose_word(kept_pos, rot_word(kept_rot), kept_stamp), 1'b1);
                kept_valid = 1'b0;
            end
        end else if (last) begin
            push_pose(pose_word(kept_pos, rot_word(kept_rot), kept_stamp), 1'b1);
            kept_valid = 1'b0;
        end
    endtask

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        errors++;
        $display("%0t: %s got %h want %h", $time, what, got, want);
    endtask

    task automatic check_pose(input logic [191:0] w, input logic eop);
        pose_out_t o;
        int offs[8]  = '{0, 32, 64, 96, 112, 128, 144, 160};
        int wids[8]  = '{32, 32, 32, 16, 16, 16, 16, 32};
        string nm[8] = '{"out_x", "out_y", "out_z", "out_qx", "out_qy", "out_qz",
                         "out_qw", "out_stamp"};
        longint unsigned g, e;
        if (due_poses.size() == 0) begin
            flag_mismatch("unexpected word", w[63:0], 0);
            return;
        end
        o = due_poses.pop_front();
        for (int i = 0; i < 8; i++) begin
            g = (w >> offs[i]) & ((64'd1 << wids[i]) - 1);
            e = (o.word >> offs[i]) & ((64'd1 << wids[i]) - 1);
            if (g != e) flag_mismatch(nm[i], g, e);
        end
        if (eop != o.eop) flag_mismatch("end_of_path", eop, o.eop);
        if (w[159:96] != {16'd0, 16'd0, 16'd0, 16'd0} && !eop) headed_seen++;
        if (eop) ends_seen++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            prune_on   <= 1'b1;
            min_gap    <= 31'd6554;
            kept_valid <= 1'b0;
            for (int i = 0; i < 3; i++) kept_pos[i] <= '0;
            for (int i = 0; i < 4; i++) kept_rot[i] <= '0;
            kept_stamp <= '0;
            due_poses.delete();
        end else begin
            if (m_tvalid && m_tready) check_pose(m_tdata, m_tlast);
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_PRUNE) prune_on = cfg_data[0];
                else min_gap = cfg_data;
            end
            if (s_tvalid && s_tready) prune_step(s_tdata, s_tuser, s_tlast);
        end
    end

    initial begin
        errors      = 0;
        headed_seen = 0;
        ends_seen   = 0;
    end

endmodule

FILE: tb/sv/path_prune_heading_test.sv
// testbench top: drives poses and register writes into the block and gives the verdict
`timescale 1ns / 1ps
module path_prune_heading_test;
    import pph_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 400;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;    // pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, rot_w, stamp
    logic         s_tuser;    // first_pose
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;    // out_x, out_y, out_z, out_qx, out_qy, out_qz, out_qw, out_stamp
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [30:0]  cfg_data;

    int errors, pending, headed_seen, ends_seen;
    int poses_sent, paths_sent, settings_used, quiet_cycles;
    logic calm;
    logic [30:0] cur_gap;
    logic [31:0] last_x, last_y;

    path_prune_heading DUT (.*);

    pph_pose_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (calm) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(99) >= 15);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("path_prune_heading: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pose(input logic [31:0] x, input logic [31:0] y, input logic first,
                             input logic last);
        logic [15:0] r[4];
        for (int i = 0; i < 4; i++) r[i] = 16'($urandom_range(32768) - 16384);
        if (!calm && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {32'($urandom), r[3], r[2], r[1], r[0], 32'($urandom), y, x};
        s_tuser  <= first;
        s_tlast  <= last;
        last_x = first ? 32'd0 : x;
        last_y = first ? 32'd0 : y;
        do @(posedge aclk); while (!s_tready);
        poses_sent++;
        if (first) paths_sent++;
    endtask

    task automatic write_reg(input logic idx, input logic [30:0] val);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_THRESH) cur_gap = val;
        settings_used++;
    endtask

    // next coordinate: small wander, near the spacing, far, or anywhere
    function automatic logic [31:0] step_coord(input logic [31:0] from);
        int mode;
        longint d;
        mode = $urandom_range(9);
        if (mode < 4) d = longint'($urandom_range(40000)) - 20000;
        else if (mode < 7) d = longint'(cur_gap) + longint'($urandom_range(6)) - 3;
        else if (mode < 9) d = longint'($urandom_range(32'h7fff_ffff));
        else return 32'($urandom);
        if ($urandom_range(1)) d = -d;
        return 32'(longint'(signed'(from)) + d);
    endfunction

    task automatic random_path();
        int n, kind;
        kind = $urandom_range(99);
        if (kind < 80) begin
            n = $urandom_range(1, 10);
            send_pose(32'($urandom), 32'($urandom), 1'b1, 1'b0);
            for (int i = 0; i < n; i++)
                send_pose(step_coord(last_x), step_coord(last_y), 1'b0, i == n - 1);
        end else if (kind < 87) begin
            send_pose(32'($urandom), 32'($urandom), 1'b0, 1'($urandom_range(1)));
        end else if (kind < 93) begin
            send_pose(32'($urandom), 32'($urandom), 1'b1, 1'b1);
        end else begin
            send_pose(32'($urandom), 32'($urandom), 1'b1, 1'b0);
            send_pose(step_coord(last_x), step_coord(last_y), 1'b0, 1'b0);
        end
    endtask

    initial begin
        logic [30:0] gaps[6];
        logic        prunes[6];
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PRUNE;
        cfg_data  = '0;
        calm      = 1'b0;
        cur_gap   = 31'd6554;
        last_x    = '0;
        last_y    = '0;
        poses_sent = 0;
        paths_sent = 0;
        settings_used = 0;
        quiet_cycles = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: defaults first
        send_pose(32'd5, 32'd5, 1'b0, 1'b0);                         // orphan pose
        send_pose(32'hdead_beef, 32'h1234_5678, 1'b1, 1'b1);         // first and last
        send_pose(32'd0, 32'd0, 1'b1, 1'b0);
        send_pose(32'd100, 32'd100, 1'b0, 1'b0);                     // too close, dropped
        send_pose(32'hffff_0000, 32'd0, 1'b0, 1'b0);                 // dx < 0, dy = 0
        send_pose(32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0);         // far jump
        send_pose(32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0);
        send_pose(32'h7fff_fff0, 32'h8000_0001, 1'b0, 1'b1);         // dropped last
        send_pose(32'd0, 32'd0, 1'b1, 1'b0);
        send_pose(32'd0, 32'hfff0_0000, 1'b0, 1'b0);                 // dy < 0
        send_pose(32'd1, 32'd1, 1'b1, 1'b0);                         // new path while open
        send_pose(32'd0, 32'd6554, 1'b0, 1'b0);                      // exactly on spacing
        send_pose(32'd0, 32'd13109, 1'b0, 1'b1);
        write_reg(CFG_PRUNE, 31'd0);
        send_pose(32'd0, 32'd0, 1'b1, 1'b0);
        send_pose(32'd0, 32'd0, 1'b0, 1'b0);                         // coincident
        send_pose(32'd7, 32'd0, 1'b0, 1'b0);
        send_pose(32'hffff_ffff, 32'h0000_0000, 1'b0, 1'b0);
        send_pose(32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b1);

        // random phases over several settings, extremes among them
        gaps   = '{31'd6554, 31'd0, 31'h7fff_ffff, 31'd3000, 31'd0, 31'd0};
        prunes = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
        gaps[4] = 31'($urandom);
        gaps[5] = 31'($urandom_range(200000));
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_PRUNE, 31'(prunes[p]));
            write_reg(CFG_THRESH, gaps[p]);
            for (int k = poses_sent; poses_sent < k + 200; ) begin
                calm = (poses_sent % 600) >= 450;
                random_path();
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        @(posedge aclk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge aclk);
        $display("%0d poses over %0d paths, %0d register writes", poses_sent, paths_sent,
                 settings_used);
        $display("%0d heading results, %0d path ends checked", headed_seen, ends_seen);
        if (errors == 0) begin
            $display("path_prune_heading: match");
        end else begin
            $display("path_prune_heading: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/pph_pkg.sv
hdl/pph_front.sv
hdl/pph_queue.sv
hdl/pph_yaw.sv
hdl/pph_back.sv
hdl/path_prune_heading.sv
hdl/pph_checker.sv
tb/sv/pph_pose_checker.sv
tb/sv/path_prune_heading_test.sv
